// ===== rtl/route_precedence_check_and_tour_cost_assert.svh =====
// Assertion helpers for the tour cost block.
`ifndef ROUTE_PRECEDENCE_CHECK_AND_TOUR_COST_ASSERT_SVH
`define ROUTE_PRECEDENCE_CHECK_AND_TOUR_COST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPCTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpctc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RPCTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpctc: next-cycle check failed");

`endif

// ===== rtl/rpctc_pkg.sv =====
package rpctc_pkg;

  localparam int PT_W     = 7;
  localparam int OP_W     = 2;
  localparam int DIN_W    = 16;
  localparam int SUM_W    = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int CFG_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ROUTE  = 2'd0,
    OP_DIST   = 2'd1,
    OP_PREC   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREC_E,
    S_PREC_L,
    S_WALK,
    S_TAIL,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/rpctc_in_if.sv =====
interface rpctc_in_if;
  logic                         valid;
  logic                         ready;
  logic [rpctc_pkg::OP_W-1:0]   op;
  logic [rpctc_pkg::PT_W-1:0]   route_point;
  logic [rpctc_pkg::PT_W-1:0]   from_point;
  logic [rpctc_pkg::PT_W-1:0]   to_point;
  logic [rpctc_pkg::DIN_W-1:0]  distance_value;
  logic [rpctc_pkg::PT_W-1:0]   earlier_point;
  logic [rpctc_pkg::PT_W-1:0]   later_point;

  modport source (
    output valid, op, route_point, from_point, to_point, distance_value,
           earlier_point, later_point,
    input  ready
  );

  modport sink (
    input  valid, op, route_point, from_point, to_point, distance_value,
           earlier_point, later_point,
    output ready
  );
endinterface

// ===== rtl/rpctc_out_if.sv =====
interface rpctc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         feasible;
  logic [rpctc_pkg::SUM_W-1:0]  total_distance;

  modport source (
    output valid, feasible, total_distance,
    input  ready
  );

  modport sink (
    input  valid, feasible, total_distance,
    output ready
  );
endinterface

// ===== rtl/rpctc_ram.sv =====
module rpctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/route_precedence_check_and_tour_cost.sv =====
// Closed-tour cost with precedence check. Items arrive on in_i; op selects a route point
// append, a distance entry write, a precedence pair or a finish. Route appends and distance
// writes leave the block idle. A precedence pair stalls input while both positions come
// through the single port of the position memory, one after the other. A finish on an
// infeasible or empty route goes to S_EMIT; otherwise the walk reads one route entry and
// one distance entry per cycle. The result beat sits in an output register, so loads go on
// while it waits; the next finish waits for that slot. Point numbers outside 1..point_count
// (clamped to 1..MAX_POINTS) are ignored, and the sum saturates at its maximum. Position
// map entries carry valid bits, so no clearing pass runs after reset or a finish.
module route_precedence_check_and_tour_cost #(
  parameter int MAX_POINTS = 64,
  parameter int DIST_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpctc_in_if.sink                       in_i,
  rpctc_out_if.source                    res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpctc_pkg::APB_AW-1:0]   paddr,
  input  logic [rpctc_pkg::APB_DW-1:0]   pwdata,
  output logic [rpctc_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  localparam int PW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int CMPW   = (CW > rpctc_pkg::PT_W) ? CW : rpctc_pkg::PT_W;
  localparam int DAW    = 2 * PW;
  localparam int DDEPTH = 1 << DAW;
  localparam int ADDW   = ((DIST_BITS > rpctc_pkg::SUM_W) ? DIST_BITS : rpctc_pkg::SUM_W) + 1;

  function automatic logic [PW-1:0] pidx(input logic [rpctc_pkg::PT_W-1:0] p);
    return PW'(p - 7'd1);
  endfunction

  function automatic logic valid_pt(input logic [rpctc_pkg::PT_W-1:0] p,
                                    input logic [CMPW-1:0] lim);
    return (p != '0) && (CMPW'(p) <= lim);
  endfunction

  rpctc_pkg::state_e state_q, state_d;
  rpctc_pkg::op_e    item_op;

  logic [rpctc_pkg::CFG_W-1:0] pc_q;
  logic [CMPW-1:0]             eff;
  logic [CW-1:0]               len_q, len_d;
  logic                        flag_q, flag_d;
  logic [MAX_POINTS-1:0]       pos_vld_q, pos_vld_d;
  logic [PW-1:0]               k_q, k_d;
  logic [PW-1:0]               e_q, l_q, pe_q, pl;
  logic                        r_vld_q, r_vld_d, r_first_q, r_first_d, r_last_q, r_last_d;
  logic                        close_q, close_d, d_vld_q, d_vld_d, d_last_q, d_last_d;
  logic [rpctc_pkg::PT_W-1:0]  first_q, prev_q;
  logic [rpctc_pkg::SUM_W-1:0] sum_q;
  logic [ADDW-1:0]             sum_ext;
  logic                        sum_clr, emit_go, in_acc, cfg_we;
  logic                        res_valid_q, res_feas_q;
  logic [rpctc_pkg::SUM_W-1:0] res_total_q;

  logic                        route_we, pos_we, dist_we;
  logic [PW-1:0]               route_addr, pos_addr, pos_wdata, pos_rdata;
  logic [rpctc_pkg::PT_W-1:0]  route_wdata, route_rdata;
  logic [DAW-1:0]              dist_addr;
  logic [DIST_BITS-1:0]        dist_wdata, dist_rdata;

  rpctc_ram #(.WIDTH(rpctc_pkg::PT_W), .DEPTH(MAX_POINTS)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .addr_i  (route_addr),
    .wdata_i (route_wdata),
    .rdata_o (route_rdata)
  );

  rpctc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .addr_i  (pos_addr),
    .wdata_i (pos_wdata),
    .rdata_o (pos_rdata)
  );

  rpctc_ram #(.WIDTH(DIST_BITS), .DEPTH(DDEPTH)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .addr_i  (dist_addr),
    .wdata_i (dist_wdata),
    .rdata_o (dist_rdata)
  );

  assign cfg_we = psel & penable & pwrite & (paddr[2] == rpctc_pkg::REG_POINT_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rpctc_pkg::REG_POINT_COUNT) ?
                  rpctc_pkg::APB_DW'(pc_q) : '0;

  always_comb begin
    if (pc_q == '0) begin
      eff = CMPW'(1);
    end else if (CMPW'(pc_q) > CMPW'(MAX_POINTS)) begin
      eff = CMPW'(MAX_POINTS);
    end else begin
      eff = CMPW'(pc_q);
    end
  end

  assign in_i.ready = (state_q == rpctc_pkg::S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign item_op    = rpctc_pkg::op_e'(in_i.op);
  assign pl         = pos_vld_q[l_q] ? pos_rdata : '0;
  assign sum_ext    = ADDW'(sum_q) + ADDW'(dist_rdata);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    flag_d      = flag_q;
    pos_vld_d   = pos_vld_q;
    k_d         = k_q;
    r_vld_d     = 1'b0;
    r_first_d   = 1'b0;
    r_last_d    = 1'b0;
    close_d     = 1'b0;
    d_vld_d     = 1'b0;
    d_last_d    = 1'b0;
    sum_clr     = 1'b0;
    emit_go     = 1'b0;
    route_we    = 1'b0;
    route_addr  = len_q[PW-1:0];
    route_wdata = in_i.route_point;
    pos_we      = 1'b0;
    pos_addr    = pidx(in_i.route_point);
    pos_wdata   = len_q[PW-1:0];
    dist_we     = 1'b0;
    dist_addr   = {pidx(in_i.from_point), pidx(in_i.to_point)};
    dist_wdata  = DIST_BITS'(in_i.distance_value);

    case (state_q)
      rpctc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (item_op)
            rpctc_pkg::OP_ROUTE: begin
              if (valid_pt(in_i.route_point, eff) && (CMPW'(len_q) < eff)) begin
                route_we                          = 1'b1;
                pos_we                            = 1'b1;
                pos_vld_d[pidx(in_i.route_point)] = 1'b1;
                len_d                             = len_q + CW'(1);
              end
            end
            rpctc_pkg::OP_DIST: begin
              dist_we = valid_pt(in_i.from_point, eff) && valid_pt(in_i.to_point, eff);
            end
            rpctc_pkg::OP_PREC: begin
              pos_addr = pidx(in_i.earlier_point);
              if (valid_pt(in_i.earlier_point, eff) && valid_pt(in_i.later_point, eff)) begin
                state_d = rpctc_pkg::S_PREC_E;
              end
            end
            rpctc_pkg::OP_FINISH: begin
              sum_clr = 1'b1;
              k_d     = '0;
              if (flag_q && (len_q != '0)) begin
                state_d = rpctc_pkg::S_WALK;
              end else begin
                state_d = rpctc_pkg::S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rpctc_pkg::S_PREC_E: begin
        pos_addr = l_q;
        state_d  = rpctc_pkg::S_PREC_L;
      end
      rpctc_pkg::S_PREC_L: begin
        if (pe_q > pl) begin
          flag_d = 1'b0;
        end
        state_d = rpctc_pkg::S_IDLE;
      end
      rpctc_pkg::S_WALK: begin
        route_addr = k_q;
        r_vld_d    = 1'b1;
        r_first_d  = (k_q == '0);
        r_last_d   = ((CW'(k_q) + CW'(1)) == len_q);
        if (r_last_d) begin
          state_d = rpctc_pkg::S_TAIL;
        end else begin
          k_d = k_q + PW'(1);
        end
      end
      rpctc_pkg::S_TAIL: begin
        if (d_vld_q && d_last_q) begin
          state_d = rpctc_pkg::S_EMIT;
        end
      end
      rpctc_pkg::S_EMIT: begin
        if (!res_valid_q || res_o.ready) begin
          emit_go   = 1'b1;
          len_d     = '0;
          flag_d    = 1'b1;
          pos_vld_d = '0;
          state_d   = rpctc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rpctc_pkg::S_IDLE;
      end
    endcase

    if (r_vld_q && !r_first_q) begin
      dist_addr = {pidx(prev_q), pidx(route_rdata)};
      d_vld_d   = 1'b1;
    end
    if (r_vld_q && r_last_q) begin
      close_d = 1'b1;
    end
    if (close_q) begin
      dist_addr = {pidx(prev_q), pidx(first_q)};
      d_vld_d   = 1'b1;
      d_last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpctc_pkg::S_IDLE;
      pc_q        <= rpctc_pkg::CFG_W'(1);
      len_q       <= '0;
      flag_q      <= 1'b1;
      pos_vld_q   <= '0;
      k_q         <= '0;
      r_vld_q     <= 1'b0;
      r_first_q   <= 1'b0;
      r_last_q    <= 1'b0;
      close_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      d_last_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      flag_q    <= flag_d;
      pos_vld_q <= pos_vld_d;
      k_q       <= k_d;
      r_vld_q   <= r_vld_d;
      r_first_q <= r_first_d;
      r_last_q  <= r_last_d;
      close_q   <= close_d;
      d_vld_q   <= d_vld_d;
      d_last_q  <= d_last_d;
      if (cfg_we) begin
        pc_q <= pwdata[rpctc_pkg::CFG_W-1:0];
      end
      if (emit_go) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q <= pidx(in_i.earlier_point);
      l_q <= pidx(in_i.later_point);
    end
    if (state_q == rpctc_pkg::S_PREC_E) begin
      pe_q <= pos_vld_q[e_q] ? pos_rdata : '0;
    end
    if (r_vld_q) begin
      prev_q <= route_rdata;
      if (r_first_q) begin
        first_q <= route_rdata;
      end
    end
    if (sum_clr) begin
      sum_q <= '0;
    end else if (d_vld_q) begin
      if (sum_ext > ADDW'(rpctc_pkg::SUM_MAX)) begin
        sum_q <= rpctc_pkg::SUM_MAX;
      end else begin
        sum_q <= sum_ext[rpctc_pkg::SUM_W-1:0];
      end
    end
    if (emit_go) begin
      res_feas_q  <= flag_q;
      res_total_q <= sum_q;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.feasible       = res_feas_q;
  assign res_o.total_distance = res_total_q;

`include "route_precedence_check_and_tour_cost_assert.svh"

  `RPCTC_ASSERT_IMPL(a_result_from_emit, $rose(res_valid_q), $past(state_q) == rpctc_pkg::S_EMIT)
  `RPCTC_ASSERT_IMPL(a_one_dist_read, r_vld_q && !r_first_q, !close_q)
  `RPCTC_ASSERT_NEXT(a_clear_after_emit, emit_go, len_q == '0 && flag_q && pos_vld_q == '0)
  `RPCTC_ASSERT_IMPL(a_len_bound, r_vld_q, CMPW'(len_q) <= CMPW'(MAX_POINTS) && len_q != '0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rpctc_pkg::*;

  localparam int MAX_PT = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [APB_AW-1:0] POINT_COUNT_ADDR = APB_AW'(4 * REG_POINT_COUNT);

  typedef struct {
    op_e              op;
    logic [PT_W-1:0]  route_point;
    logic [PT_W-1:0]  from_point;
    logic [PT_W-1:0]  to_point;
    logic [DIN_W-1:0] distance_value;
    logic [PT_W-1:0]  earlier_point;
    logic [PT_W-1:0]  later_point;
  } tour_item_t;

  typedef struct {
    bit               feasible;
    logic [SUM_W-1:0] total_distance;
  } tour_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rpctc_in_if  in_if ();
  rpctc_out_if res_if ();

  route_precedence_check_and_tour_cost #(
    .MAX_POINTS(MAX_PT),
    .DIST_BITS (DIN_W)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tour_item_t   pending_items[$];
  tour_result_t expected_tours[$];
  tour_item_t   next_beat;
  tour_item_t   seen_beat;
  tour_result_t due_tour;
  bit           failed;
  int           send_gap;
  int           recv_gap;
  bit           send_burst;
  bit           recv_burst;
  int           stall_cycles;
  int           phase_count;

  logic [CFG_W-1:0] point_count_cfg = CFG_W'(1);

  logic [DIN_W-1:0] dist_mem [MAX_PT*MAX_PT];
  logic [PT_W-1:0]  route_mem [MAX_PT];
  logic [5:0]       pos_mem [MAX_PT+1];
  int               route_len;
  bit               feas_flag = 1'b1;

  int gen_route[$];
  int gen_pos [MAX_PT+1];
  bit gen_written [MAX_PT*MAX_PT];

  function automatic int active_points();
    if (point_count_cfg == 0) return 1;
    if (point_count_cfg > MAX_PT) return MAX_PT;
    return int'(point_count_cfg);
  endfunction

  function automatic bit point_ok(logic [PT_W-1:0] p);
    return p >= 1 && int'(p) <= active_points();
  endfunction

  function automatic void apply_tour_item(tour_item_t it);
    tour_result_t res;
    longint walk_sum;
    int a, b;
    case (it.op)
      OP_ROUTE: begin
        if (point_ok(it.route_point) && route_len < active_points()) begin
          route_mem[route_len] = it.route_point;
          pos_mem[it.route_point] = 6'(route_len);
          route_len++;
        end
      end
      OP_DIST: begin
        if (point_ok(it.from_point) && point_ok(it.to_point)) begin
          a = it.from_point;
          b = it.to_point;
          dist_mem[(a - 1) * MAX_PT + b - 1] = it.distance_value;
        end
      end
      OP_PREC: begin
        if (point_ok(it.earlier_point) && point_ok(it.later_point)) begin
          if (pos_mem[it.earlier_point] > pos_mem[it.later_point]) feas_flag = 1'b0;
        end
      end
      default: begin
        res.feasible = feas_flag;
        res.total_distance = '0;
        if (feas_flag && route_len > 0) begin
          walk_sum = 0;
          for (int i = 0; i < route_len; i++) begin
            a = route_mem[i];
            b = route_mem[(i + 1) % route_len];
            walk_sum += dist_mem[(a - 1) * MAX_PT + b - 1];
            if (walk_sum > SUM_MAX) walk_sum = SUM_MAX;
          end
          res.total_distance = SUM_W'(walk_sum);
        end
        expected_tours.push_back(res);
        route_len = 0;
        feas_flag = 1'b1;
        foreach (pos_mem[i]) pos_mem[i] = '0;
      end
    endcase
  endfunction

  function automatic tour_item_t blank_item(op_e kind);
    tour_item_t it;
    it.op = kind;
    it.route_point = PT_W'($urandom_range(0, 127));
    it.from_point = PT_W'($urandom_range(0, 127));
    it.to_point = PT_W'($urandom_range(0, 127));
    it.distance_value = DIN_W'($urandom);
    it.earlier_point = PT_W'($urandom_range(0, 127));
    it.later_point = PT_W'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic logic [DIN_W-1:0] rand_distance();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void push_item(tour_item_t it, bit counted);
    int p, f, t;
    case (it.op)
      OP_ROUTE: begin
        p = it.route_point;
        if (point_ok(it.route_point) && gen_route.size() < active_points()) begin
          gen_pos[p] = gen_route.size();
          gen_route.push_back(p);
        end
      end
      OP_DIST: begin
        f = it.from_point;
        t = it.to_point;
        if (point_ok(it.from_point) && point_ok(it.to_point)) begin
          gen_written[(f - 1) * MAX_PT + t - 1] = 1'b1;
        end
      end
      OP_FINISH: begin
        gen_route.delete();
        foreach (gen_pos[i]) gen_pos[i] = 0;
      end
      default: ;
    endcase
    pending_items.push_back(it);
    if (counted) phase_count++;
  endfunction

  function automatic void add_route(int p);
    tour_item_t it;
    it = blank_item(OP_ROUTE);
    it.route_point = PT_W'(p);
    push_item(it, 1'b1);
  endfunction

  function automatic void add_dist(int f, int t, logic [DIN_W-1:0] d);
    tour_item_t it;
    it = blank_item(OP_DIST);
    it.from_point = PT_W'(f);
    it.to_point = PT_W'(t);
    it.distance_value = d;
    push_item(it, 1'b1);
  endfunction

  function automatic void add_prec(int e, int l);
    tour_item_t it;
    it = blank_item(OP_PREC);
    it.earlier_point = PT_W'(e);
    it.later_point = PT_W'(l);
    push_item(it, 1'b1);
  endfunction

  // Most pairs come from the route loaded so far and usually hold.
  function automatic void add_precedence();
    int e, l, tmp;
    bit hold;
    if (gen_route.size() == 0 || $urandom_range(0, 5) == 0) begin
      e = $urandom_range(1, active_points());
      l = $urandom_range(1, active_points());
    end else begin
      e = gen_route[$urandom_range(0, gen_route.size() - 1)];
      l = gen_route[$urandom_range(0, gen_route.size() - 1)];
      hold = $urandom_range(0, 3) != 0;
      if (hold == (gen_pos[e] > gen_pos[l])) begin
        tmp = e;
        e = l;
        l = tmp;
      end
    end
    add_prec(e, l);
  endfunction

  // Every edge of the tour gets a distance entry before the walk reads it.
  function automatic void add_finish();
    int n, f, t;
    n = gen_route.size();
    for (int i = 0; i < n; i++) begin
      f = gen_route[i];
      t = gen_route[(i + 1) % n];
      if (!gen_written[(f - 1) * MAX_PT + t - 1]) add_dist(f, t, rand_distance());
    end
    push_item(blank_item(OP_FINISH), 1'b1);
  endfunction

  function automatic void run_tour();
    int len, n, pts;
    pts = active_points();
    n = $urandom_range(0, 19);
    if (n == 0) len = 0;
    else if (pts <= 8 || n <= 3) len = $urandom_range(1, pts + 1);
    else len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) push_item(blank_item(op_e'($urandom_range(0, 2))), 1'b0);
      if ($urandom_range(0, 7) == 0) add_precedence();
      add_route($urandom_range(1, pts));
    end
    repeat ($urandom_range(0, 3)) add_precedence();
    repeat ($urandom_range(0, 2)) begin
      add_dist($urandom_range(1, pts), $urandom_range(1, pts), rand_distance());
    end
    add_finish();
  endfunction

  task automatic settle();
    while (pending_items.size() != 0 || expected_tours.size() != 0 || in_if.valid) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_point_count(int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= POINT_COUNT_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    point_count_cfg = CFG_W'(value);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_if.ready) begin
        if (in_if.valid) begin
          send_gap = send_burst ? 0 : $urandom_range(0, 6);
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        end
        if (send_gap == 0 && pending_items.size() != 0) begin
          next_beat = pending_items.pop_front();
          in_if.op <= next_beat.op;
          in_if.route_point <= next_beat.route_point;
          in_if.from_point <= next_beat.from_point;
          in_if.to_point <= next_beat.to_point;
          in_if.distance_value <= next_beat.distance_value;
          in_if.earlier_point <= next_beat.earlier_point;
          in_if.later_point <= next_beat.later_point;
          in_if.valid <= 1'b1;
        end else begin
          if (send_gap > 0) send_gap--;
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen_beat.op = op_e'(in_if.op);
        seen_beat.route_point = in_if.route_point;
        seen_beat.from_point = in_if.from_point;
        seen_beat.to_point = in_if.to_point;
        seen_beat.distance_value = in_if.distance_value;
        seen_beat.earlier_point = in_if.earlier_point;
        seen_beat.later_point = in_if.later_point;
        apply_tour_item(seen_beat);
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_tours.size() == 0) begin
          $error("result beat with no tour pending: feasible %0d, total_distance %0d",
                 res_if.feasible, res_if.total_distance);
          failed = 1'b1;
        end else begin
          due_tour = expected_tours.pop_front();
          if (res_if.feasible !== due_tour.feasible) begin
            $error("feasible mismatch: expected %0d, actual %0d",
                   due_tour.feasible, res_if.feasible);
            failed = 1'b1;
          end
          if (res_if.total_distance !== due_tour.total_distance) begin
            $error("total_distance mismatch: expected %0d, actual %0d",
                   due_tour.total_distance, res_if.total_distance);
            failed = 1'b1;
          end
        end
        recv_gap = recv_burst ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_points [9];
    phase_points = '{1, 64, 2, 0, 9, 127, 3, 40, 6};
    phase_points[7] = $urandom_range(10, 63);
    in_if.valid = 1'b0;
    in_if.op = OP_ROUTE;
    in_if.route_point = '0;
    in_if.from_point = '0;
    in_if.to_point = '0;
    in_if.distance_value = '0;
    in_if.earlier_point = '0;
    in_if.later_point = '0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (pos_mem[i]) pos_mem[i] = '0;
    foreach (gen_pos[i]) gen_pos[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset point count only point 1 exists.
    add_route(1);
    add_route(2);
    add_finish();
    settle();
    write_point_count(4);
    add_finish();
    add_dist(1, 2, '1);
    add_dist(2, 3, '0);
    add_dist(3, 1, 7);
    add_dist(0, 2, 9);
    add_dist(127, 127, 1234);
    add_route(1);
    add_route(0);
    add_route(127);
    add_prec(3, 1);
    add_route(2);
    add_prec(1, 2);
    add_prec(0, 127);
    add_route(3);
    add_finish();
    add_route(2);
    add_route(1);
    add_prec(1, 2);
    add_finish();
    add_dist(4, 4, '1);
    repeat (5) add_route(4);
    add_finish();

    foreach (phase_points[i]) begin
      settle();
      write_point_count(phase_points[i]);
      phase_count = 0;
      while (phase_count < 195) run_tour();
    end
    settle();
    if (!failed && expected_tours.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
